FILE: src/lav_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_pkg - shared types and constants of the look-at view matrix block
// Fixed field widths, row codes and small helpers.
// ----------------------------------------------------------------------------
package lav_pkg;

    localparam int DIR_W = 16;
    localparam int POS_W = 32;
    localparam int CRS_W = 33;   // exact cross product of two 16 bit vectors

    typedef logic signed [DIR_W-1:0] dir_t;
    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic signed [CRS_W-1:0] crs_t;

    localparam logic [1:0] ROW_RIGHT = 2'd0;
    localparam logic [1:0] ROW_UP    = 2'd1;
    localparam logic [1:0] ROW_FWD   = 2'd2;

    // negate with saturation (-32768 -> 32767)
    function automatic dir_t neg_sat(input dir_t v);
        dir_t r;
        if (v == 16'sh8000) begin
            r = 16'sh7FFF;
        end else begin
            r = -v;
        end
        return r;
    endfunction

endpackage

FILE: src/lav_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_norm - pipelined vector normaliser
// Sum of squares, bit-per-stage square root, bit-per-stage rounded division
// of each component by the root, saturation to 16 bits. Advances only
// while en is high.
// ----------------------------------------------------------------------------
module lav_norm import lav_pkg::*; #(
    parameter int DIR_FRAC_BITS = 14
) (
    input  logic aclk,
    input  logic en,
    input  crs_t c_in [3],
    output dir_t v_out [3],
    output logic zero_out
);

    localparam int SQ_STEPS = 32;
    localparam int DS       = DIR_FRAC_BITS + 1;   // quotient bits
    localparam int NW       = DIR_FRAC_BITS + 33;  // scaled numerator bits

    // squares and sum
    logic signed [65:0] sq_prod [3];
    logic [63:0] sq_reg [3];
    crs_t        c0_reg [3];
    logic [63:0] sum_reg;
    crs_t        c1_reg [3];

    // square root stages
    logic [63:0] x_st     [SQ_STEPS];
    logic [63:0] root_st  [SQ_STEPS];
    crs_t        c_st     [SQ_STEPS][3];
    logic [63:0] trial    [SQ_STEPS];
    logic [63:0] x_next   [SQ_STEPS];
    logic [63:0] root_next[SQ_STEPS];
    logic [63:0] x_reg    [SQ_STEPS];
    logic [63:0] root_reg [SQ_STEPS];
    crs_t        cs_reg   [SQ_STEPS][3];

    // division set-up
    logic [31:0]    n_w;
    logic [31:0]    mag_w [3];
    logic [NW-1:0]  num_w [3];
    logic [31:0]    n_p_reg;
    logic [31:0]    rem_p_reg [3];
    logic [DS-1:0]  low_p_reg [3];
    logic           neg_p_reg [3];

    // division stages
    logic [31:0]   rem_st   [DS][3];
    logic [DS-1:0] low_st   [DS][3];
    logic [DS-1:0] q_st     [DS][3];
    logic          neg_st   [DS][3];
    logic [31:0]   n_st     [DS];
    logic [32:0]   part     [DS][3];
    logic [31:0]   rem_next [DS][3];
    logic [DS-1:0] low_next [DS][3];
    logic [DS-1:0] q_next   [DS][3];
    logic [31:0]   rem_reg  [DS][3];
    logic [DS-1:0] low_reg  [DS][3];
    logic [DS-1:0] q_reg    [DS][3];
    logic          neg_reg  [DS][3];
    logic [31:0]   nd_reg   [DS];

    // output
    logic [31:0] qe_w [3];
    dir_t        v_next [3];
    dir_t        v_reg [3];
    logic        zero_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sq_prod[i] = c_in[i] * c_in[i];
        end
    end

    // square root: one result bit per stage
    always_comb begin
        x_st[0]    = sum_reg;
        root_st[0] = 64'd0;
        for (int i = 0; i < 3; i++) begin
            c_st[0][i] = c1_reg[i];
        end
        for (int k = 1; k < SQ_STEPS; k++) begin
            x_st[k]    = x_reg[k-1];
            root_st[k] = root_reg[k-1];
            for (int i = 0; i < 3; i++) begin
                c_st[k][i] = cs_reg[k-1][i];
            end
        end
        for (int k = 0; k < SQ_STEPS; k++) begin
            trial[k] = root_st[k] + (64'd1 << (62 - 2 * k));
            if (x_st[k] >= trial[k]) begin
                x_next[k]    = x_st[k] - trial[k];
                root_next[k] = (root_st[k] >> 1) + (64'd1 << (62 - 2 * k));
            end else begin
                x_next[k]    = x_st[k];
                root_next[k] = root_st[k] >> 1;
            end
        end
    end

    // numerator |c| * 2^F + n/2, split into starting remainder and low bits
    always_comb begin
        n_w = root_reg[SQ_STEPS-1][31:0];
        for (int i = 0; i < 3; i++) begin
            mag_w[i] = cs_reg[SQ_STEPS-1][i][CRS_W-1] ? 32'(-cs_reg[SQ_STEPS-1][i])
                                                       : cs_reg[SQ_STEPS-1][i][31:0];
            num_w[i] = (NW'(mag_w[i]) << DIR_FRAC_BITS) + NW'(n_w >> 1);
        end
    end

    // restoring division: one quotient bit per stage
    always_comb begin
        n_st[0] = n_p_reg;
        for (int i = 0; i < 3; i++) begin
            rem_st[0][i] = rem_p_reg[i];
            low_st[0][i] = low_p_reg[i];
            q_st[0][i]   = '0;
            neg_st[0][i] = neg_p_reg[i];
        end
        for (int k = 1; k < DS; k++) begin
            n_st[k] = nd_reg[k-1];
            for (int i = 0; i < 3; i++) begin
                rem_st[k][i] = rem_reg[k-1][i];
                low_st[k][i] = low_reg[k-1][i];
                q_st[k][i]   = q_reg[k-1][i];
                neg_st[k][i] = neg_reg[k-1][i];
            end
        end
        for (int k = 0; k < DS; k++) begin
            for (int i = 0; i < 3; i++) begin
                part[k][i]     = {rem_st[k][i], low_st[k][i][DS-1]};
                low_next[k][i] = low_st[k][i] << 1;
                if (part[k][i] >= {1'b0, n_st[k]}) begin
                    rem_next[k][i] = 32'(part[k][i] - {1'b0, n_st[k]});
                    q_next[k][i]   = {q_st[k][i][DS-2:0], 1'b1};
                end else begin
                    rem_next[k][i] = part[k][i][31:0];
                    q_next[k][i]   = {q_st[k][i][DS-2:0], 1'b0};
                end
            end
        end
    end

    // sign, saturation, zero length
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            qe_w[i] = 32'(q_reg[DS-1][i]);
            if (nd_reg[DS-1] == 32'd0) begin
                v_next[i] = '0;
            end else if (!neg_reg[DS-1][i]) begin
                v_next[i] = (qe_w[i] > 32'd32767) ? 16'sh7FFF : qe_w[i][15:0];
            end else begin
                v_next[i] = (qe_w[i] > 32'd32768) ? 16'sh8000 : 16'(~qe_w[i] + 32'd1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= sq_prod[i][63:0];
                c0_reg[i] <= c_in[i];
                c1_reg[i] <= c0_reg[i];
            end
            sum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            for (int k = 0; k < SQ_STEPS; k++) begin
                x_reg[k]    <= x_next[k];
                root_reg[k] <= root_next[k];
                for (int i = 0; i < 3; i++) begin
                    cs_reg[k][i] <= c_st[k][i];
                end
            end
            n_p_reg <= n_w;
            for (int i = 0; i < 3; i++) begin
                rem_p_reg[i] <= num_w[i][NW-1:DS];
                low_p_reg[i] <= num_w[i][DS-1:0];
                neg_p_reg[i] <= cs_reg[SQ_STEPS-1][i][CRS_W-1];
            end
            for (int k = 0; k < DS; k++) begin
                nd_reg[k] <= n_st[k];
                for (int i = 0; i < 3; i++) begin
                    rem_reg[k][i] <= rem_next[k][i];
                    low_reg[k][i] <= low_next[k][i];
                    q_reg[k][i]   <= q_next[k][i];
                    neg_reg[k][i] <= neg_st[k][i];
                end
            end
            for (int i = 0; i < 3; i++) begin
                v_reg[i] <= v_next[i];
            end
            zero_reg <= (nd_reg[DS-1] == 32'd0);
        end
    end

    assign v_out    = v_reg;
    assign zero_out = zero_reg;

endmodule

FILE: src/look_at_view_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix - world-to-camera matrix of a look-at camera
// Takes a pose (forward, up hint, eye) and returns the three view matrix
// rows right, true up and -forward, each with its saturated translation.
// ----------------------------------------------------------------------------
//  Channel | Dir | Payload                                        | Per item
//  s_      | in  | tdata: forward, up_hint, eye                   | 1 pose
//  m_      | out | tdata: row x/y/z, offset; tuser: index, degen  | 3 rows
//
//  The first row's delay after the accepting edge is set mostly by the two
//  normaliser pipelines, each with a 32 stage square root and a
//  DIR_FRAC_BITS + 1 stage divider.
//  A pose can enter every cycle while the output register is empty or its
//  last row is being taken; the output emits three rows per pose and holds
//  the pipeline until the last row is taken.
//  Reset (aresetn low, synchronous) clears valid bits and the row counter.
//  Stalls freeze the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module look_at_view_matrix import lav_pkg::*; #(
    parameter int DIR_FRAC_BITS = 14
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // forward_x, forward_y, forward_z, up_hint_x, up_hint_y, up_hint_z,
    // eye_x, eye_y, eye_z
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // row_x, row_y, row_z, row_offset
    output logic [79:0]  m_tdata,
    // row_index, degenerate
    output logic [2:0]   m_tuser,
    output logic         m_tlast
);

    localparam int NL = DIR_FRAC_BITS + 37;   // normaliser latency

    logic adv;          // pipeline advance
    logic out_hs;

    // s0: input registers
    dir_t f0_reg [3];
    dir_t u0_reg [3];
    pos_t p0_reg [3];
    logic v0_reg;

    // s1: cross f x u products
    logic signed [31:0] pa1_reg [3];
    logic signed [31:0] pb1_reg [3];
    dir_t f1_reg [3];
    pos_t p1_reg [3];
    logic v1_reg;

    // s2: cross f x u
    crs_t c2_reg [3];
    dir_t f2_reg [3];
    pos_t p2_reg [3];
    logic v2_reg;

    // first normaliser and its side line
    dir_t r_w [3];
    logic rz_w;
    dir_t fd1_reg [NL][3];
    pos_t pd1_reg [NL][3];
    logic vd1_reg [NL];

    // s3: r x f products, dot products
    logic signed [31:0] qa3_reg [3];
    logic signed [31:0] qb3_reg [3];
    logic signed [47:0] rp3_reg [3];
    logic signed [47:0] fp3_reg [3];
    dir_t r3_reg [3];
    dir_t f3_reg [3];
    pos_t p3_reg [3];
    logic z3_reg;
    logic v3_reg;

    // s4: cross r x f, dot sums
    crs_t c4_reg [3];
    logic signed [49:0] srp4_reg;
    logic signed [49:0] sfp4_reg;
    dir_t r4_reg [3];
    dir_t f4_reg [3];
    pos_t p4_reg [3];
    logic z4_reg;
    logic v4_reg;

    // second normaliser and its side line
    dir_t t_w [3];
    logic tz_w;
    dir_t rd2_reg [NL][3];
    dir_t fd2_reg [NL][3];
    pos_t pd2_reg [NL][3];
    logic signed [49:0] srpd2_reg [NL];
    logic signed [49:0] sfpd2_reg [NL];
    logic zd2_reg [NL];
    logic vd2_reg [NL];

    // s5: t.p products, rows 0 and 2 offsets rounded
    logic signed [47:0] tp5_reg [3];
    dir_t t5_reg [3];
    dir_t r5_reg [3];
    dir_t f5_reg [3];
    pos_t off0_5_reg;
    pos_t off2_5_reg;
    logic z5_reg;
    logic v5_reg;

    // s6: t.p sum
    logic signed [49:0] stp6_reg;
    dir_t t6_reg [3];
    dir_t r6_reg [3];
    dir_t f6_reg [3];
    pos_t off0_6_reg;
    pos_t off2_6_reg;
    logic z6_reg;
    logic v6_reg;

    // s7: output register, held while the three rows go out
    dir_t r7_reg [3];
    dir_t t7_reg [3];
    dir_t nf7_reg [3];
    pos_t off7_reg [3];
    logic deg7_reg;
    logic v7_reg;

    logic [1:0] row_cnt_reg;
    logic [1:0] row_cnt_next;
    dir_t row_w [3];
    pos_t off_w;

    // shift right by DIR_FRAC_BITS, round half away from zero, optional
    // negate, saturate to 32 bits
    function automatic pos_t round_off(input logic signed [49:0] s, input logic negate);
        logic [49:0] mag;
        logic [49:0] q;
        logic        neg;
        pos_t        r;
        mag = s[49] ? 50'(-s) : 50'(s);
        q   = (mag + (50'd1 << (DIR_FRAC_BITS - 1))) >> DIR_FRAC_BITS;
        neg = s[49] ^ negate;
        if (!neg) begin
            r = (q > 50'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
        end else begin
            r = (q > 50'h0_8000_0000) ? 32'sh8000_0000 : 32'(~q[31:0] + 32'd1);
        end
        return r;
    endfunction

    assign out_hs   = v7_reg && m_tready;
    assign adv      = !v7_reg || (m_tready && (row_cnt_reg == ROW_FWD));
    assign s_tready = adv;

    lav_norm #(.DIR_FRAC_BITS(DIR_FRAC_BITS)) u_norm_right (
        .aclk     (aclk),
        .en       (adv),
        .c_in     (c2_reg),
        .v_out    (r_w),
        .zero_out (rz_w)
    );

    lav_norm #(.DIR_FRAC_BITS(DIR_FRAC_BITS)) u_norm_up (
        .aclk     (aclk),
        .en       (adv),
        .c_in     (c4_reg),
        .v_out    (t_w),
        .zero_out (tz_w)
    );

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            for (int k = 0; k < NL; k++) begin
                vd1_reg[k] <= 1'b0;
                vd2_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            v0_reg     <= s_tvalid;
            v1_reg     <= v0_reg;
            v2_reg     <= v1_reg;
            vd1_reg[0] <= v2_reg;
            for (int k = 1; k < NL; k++) begin
                vd1_reg[k] <= vd1_reg[k-1];
                vd2_reg[k] <= vd2_reg[k-1];
            end
            v3_reg     <= vd1_reg[NL-1];
            v4_reg     <= v3_reg;
            vd2_reg[0] <= v4_reg;
            v5_reg     <= vd2_reg[NL-1];
            v6_reg     <= v5_reg;
            v7_reg     <= v6_reg;
        end
    end

    // data path
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                f0_reg[i] <= s_tdata[16*i +: 16];
                u0_reg[i] <= s_tdata[48 + 16*i +: 16];
                p0_reg[i] <= s_tdata[96 + 32*i +: 32];
            end

            pa1_reg[0] <= f0_reg[1] * u0_reg[2];
            pb1_reg[0] <= f0_reg[2] * u0_reg[1];
            pa1_reg[1] <= f0_reg[2] * u0_reg[0];
            pb1_reg[1] <= f0_reg[0] * u0_reg[2];
            pa1_reg[2] <= f0_reg[0] * u0_reg[1];
            pb1_reg[2] <= f0_reg[1] * u0_reg[0];
            f1_reg <= f0_reg;
            p1_reg <= p0_reg;

            for (int i = 0; i < 3; i++) begin
                c2_reg[i] <= pa1_reg[i] - pb1_reg[i];
            end
            f2_reg <= f1_reg;
            p2_reg <= p1_reg;

            fd1_reg[0] <= f2_reg;
            pd1_reg[0] <= p2_reg;
            for (int k = 1; k < NL; k++) begin
                fd1_reg[k] <= fd1_reg[k-1];
                pd1_reg[k] <= pd1_reg[k-1];
            end

            qa3_reg[0] <= r_w[1] * fd1_reg[NL-1][2];
            qb3_reg[0] <= r_w[2] * fd1_reg[NL-1][1];
            qa3_reg[1] <= r_w[2] * fd1_reg[NL-1][0];
            qb3_reg[1] <= r_w[0] * fd1_reg[NL-1][2];
            qa3_reg[2] <= r_w[0] * fd1_reg[NL-1][1];
            qb3_reg[2] <= r_w[1] * fd1_reg[NL-1][0];
            for (int i = 0; i < 3; i++) begin
                rp3_reg[i] <= r_w[i] * pd1_reg[NL-1][i];
                fp3_reg[i] <= fd1_reg[NL-1][i] * pd1_reg[NL-1][i];
            end
            r3_reg <= r_w;
            f3_reg <= fd1_reg[NL-1];
            p3_reg <= pd1_reg[NL-1];
            z3_reg <= rz_w;

            for (int i = 0; i < 3; i++) begin
                c4_reg[i] <= qa3_reg[i] - qb3_reg[i];
            end
            srp4_reg <= rp3_reg[0] + rp3_reg[1] + rp3_reg[2];
            sfp4_reg <= fp3_reg[0] + fp3_reg[1] + fp3_reg[2];
            r4_reg <= r3_reg;
            f4_reg <= f3_reg;
            p4_reg <= p3_reg;
            z4_reg <= z3_reg;

            rd2_reg[0]   <= r4_reg;
            fd2_reg[0]   <= f4_reg;
            pd2_reg[0]   <= p4_reg;
            srpd2_reg[0] <= srp4_reg;
            sfpd2_reg[0] <= sfp4_reg;
            zd2_reg[0]   <= z4_reg;
            for (int k = 1; k < NL; k++) begin
                rd2_reg[k]   <= rd2_reg[k-1];
                fd2_reg[k]   <= fd2_reg[k-1];
                pd2_reg[k]   <= pd2_reg[k-1];
                srpd2_reg[k] <= srpd2_reg[k-1];
                sfpd2_reg[k] <= sfpd2_reg[k-1];
                zd2_reg[k]   <= zd2_reg[k-1];
            end

            for (int i = 0; i < 3; i++) begin
                tp5_reg[i] <= t_w[i] * pd2_reg[NL-1][i];
            end
            t5_reg     <= t_w;
            r5_reg     <= rd2_reg[NL-1];
            f5_reg     <= fd2_reg[NL-1];
            off0_5_reg <= round_off(srpd2_reg[NL-1], 1'b1);
            off2_5_reg <= round_off(sfpd2_reg[NL-1], 1'b0);
            z5_reg     <= zd2_reg[NL-1] | tz_w;

            stp6_reg   <= tp5_reg[0] + tp5_reg[1] + tp5_reg[2];
            t6_reg     <= t5_reg;
            r6_reg     <= r5_reg;
            f6_reg     <= f5_reg;
            off0_6_reg <= off0_5_reg;
            off2_6_reg <= off2_5_reg;
            z6_reg     <= z5_reg;

            r7_reg <= r6_reg;
            t7_reg <= t6_reg;
            for (int i = 0; i < 3; i++) begin
                nf7_reg[i] <= neg_sat(f6_reg[i]);
            end
            off7_reg[0] <= off0_6_reg;
            off7_reg[1] <= round_off(stp6_reg, 1'b1);
            off7_reg[2] <= off2_6_reg;
            deg7_reg    <= z6_reg;
        end
    end

    // row sequencing on the output
    always_comb begin
        row_cnt_next = row_cnt_reg;
        if (out_hs) begin
            row_cnt_next = (row_cnt_reg == ROW_FWD) ? ROW_RIGHT : row_cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg <= ROW_RIGHT;
        end else begin
            row_cnt_reg <= row_cnt_next;
        end
    end

    always_comb begin
        case (row_cnt_reg)
            ROW_RIGHT: begin
                row_w = r7_reg;
                off_w = off7_reg[0];
            end
            ROW_UP: begin
                row_w = t7_reg;
                off_w = off7_reg[1];
            end
            ROW_FWD: begin
                row_w = nf7_reg;
                off_w = off7_reg[2];
            end
            default: begin
                row_w = nf7_reg;
                off_w = off7_reg[2];
            end
        endcase
    end

    assign m_tvalid = v7_reg;
    assign m_tdata  = {off_w, row_w[2], row_w[1], row_w[0]};
    assign m_tuser  = {deg7_reg, row_cnt_reg};
    assign m_tlast  = (row_cnt_reg == ROW_FWD);

endmodule
